[hw/rtl/srmc_pkg.sv]
package srmc_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned DistW    = PosW + 1;
  localparam int unsigned GainW    = 16;
  localparam int unsigned RateW    = 16;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned TickCntW = 16;
  localparam int unsigned OpW      = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivSteps = PeriodW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam int unsigned TickRateDef      = 8000;
  localparam int unsigned ControlDivideDef = 80;

  localparam logic [OpW-1:0] OpTick     = 3'd0;
  localparam logic [OpW-1:0] OpTarget   = 3'd1;
  localparam logic [OpW-1:0] OpVelocity = 3'd2;
  localparam logic [OpW-1:0] OpHome     = 3'd3;
  localparam logic [OpW-1:0] OpZero     = 3'd4;

  localparam logic [CfgIdxW-1:0] RegAccelGain = 4'd0;
  localparam logic [CfgIdxW-1:0] RegDecelGain = 4'd1;
  localparam logic [CfgIdxW-1:0] RegMaxRate   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegMinRate   = 4'd3;

  localparam logic [GainW-1:0] AccelGainRst = 16'd1;
  localparam logic [GainW-1:0] DecelGainRst = 16'd1;
  localparam logic [RateW-1:0] MaxRateRst   = 16'd1600;
  localparam logic [RateW-1:0] MinRateRst   = 16'd44;

  localparam logic [PeriodW-1:0] PeriodSat = '1;

  typedef enum logic [1:0] {
    DirStop  = 2'd0,
    DirPlus  = 2'd1,
    DirMinus = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    HomeOff    = 2'd0,
    HomeSearch = 2'd1,
    HomeFound  = 2'd2
  } home_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StMulDecel,
    StMulAccel,
    StSelect,
    StDiv,
    StFinish
  } state_e;

endpackage

[hw/rtl/srmc_if.sv]
interface srmc_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [srmc_pkg::OpW-1:0]       op;
  logic signed [srmc_pkg::PosW-1:0] value;
  logic                           home_switch;

  modport source (output valid, output op, output value, output home_switch, input ready);
  modport sink   (input valid, input op, input value, input home_switch, output ready);
endinterface

interface srmc_res_if;
  logic                             valid;
  logic                             ready;
  logic                             step_pulse;
  logic                             step_dir;
  logic signed [srmc_pkg::PosW-1:0] position;
  logic                             homed;

  modport source (output valid, output step_pulse, output step_dir, output position,
                  output homed, input ready);
  modport sink   (input valid, input step_pulse, input step_dir, input position,
                  input homed, output ready);
endinterface

interface srmc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srmc_pkg::CfgIdxW-1:0]      index;
  logic [srmc_pkg::CfgDataW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/stepper_ramp_motion_controller.sv]
// Stepper ramp controller. Requests arrive on cmd_i: a tick, a new target,
// a signed velocity, a homing search or a zeroing of all positions. Every
// request yields exactly one result on res_o with the step pulse, the
// direction pin level, the position after the request and the homed flag.
// Gains and rate limits are written on cfg_i at any time the block is idle;
// cfg_i is always ready.
// One request is in work at a time. A plain tick, a target or a zeroing
// request goes straight to StFinish, a velocity or homing request with a
// non-zero speed passes StDiv, and a tick that runs a control update passes
// StPrep, StMulDecel, StMulAccel, StSelect and StDiv (no StDiv for a zero
// clamped rate). StFinish loads the result, then a next request can be taken.
// A restoring divider resolves the step period one quotient bit a cycle, fed
// by one shared 16x16 multiplier that forms both ramp terms in turn.
// The result sits in an output register, so cmd_i takes the next request
// while a result still waits on a stalled receiver; only when a second result
// is ready and the first has not been taken does the block hold in place.
// Reset clears all positions, stops the motor, selects velocity mode with a
// zero period and restores the register defaults.
module stepper_ramp_motion_controller #(
  parameter int unsigned TickRate      = srmc_pkg::TickRateDef,
  parameter int unsigned ControlDivide = srmc_pkg::ControlDivideDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  srmc_cmd_if.sink         cmd_i,
  srmc_res_if.source       res_o,
  srmc_cfg_if.sink         cfg_i
);

  localparam int unsigned PosW    = srmc_pkg::PosW;
  localparam int unsigned DistW   = srmc_pkg::DistW;
  localparam int unsigned GainW   = srmc_pkg::GainW;
  localparam int unsigned RateW   = srmc_pkg::RateW;
  localparam int unsigned PeriodW = srmc_pkg::PeriodW;
  localparam int unsigned TickW   = srmc_pkg::TickCntW;
  localparam int unsigned DivCntW = srmc_pkg::DivCntW;
  localparam int unsigned SatW    = RateW + 1;

  localparam logic [PeriodW-1:0] Dividend   = PeriodW'(TickRate);
  localparam logic [TickW-1:0]   CtlDivide  = TickW'(ControlDivide);
  localparam logic [SatW-1:0]    SatProduct = SatW'(1) << RateW;
  localparam logic [DivCntW-1:0] DivLast    = DivCntW'(srmc_pkg::DivSteps - 1);

  srmc_pkg::state_e state_q, state_d;

  logic [GainW-1:0] accel_gain_q, decel_gain_q;
  logic [RateW-1:0] max_rate_q, min_rate_q;

  logic [PosW-1:0]    cur_pos_q, cur_pos_d;
  logic [PosW-1:0]    tgt_pos_q, tgt_pos_d;
  logic [PosW-1:0]    start_pos_q, start_pos_d;
  srmc_pkg::dir_e     dir_q, dir_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [TickW-1:0]   step_ticks_q, step_ticks_d;
  logic [TickW-1:0]   ctl_ticks_q, ctl_ticks_d;
  logic               pos_mode_q, pos_mode_d;
  srmc_pkg::home_e    home_q, home_d;
  logic               dir_pin_q, dir_pin_d;

  logic [srmc_pkg::OpW-1:0] op_q, op_d;
  logic                     sw_q, sw_d;

  logic [DistW-1:0]   dist_tgt_q, dist_tgt_d;
  logic [DistW-1:0]   dist_start_q, dist_start_d;
  logic [SatW-1:0]    prod_tgt_q, prod_tgt_d;
  logic [SatW-1:0]    prod_start_q, prod_start_d;

  logic [SatW-1:0]    divisor_q, divisor_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [PeriodW-1:0] quo_q, quo_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  logic               res_valid_q, res_valid_d;
  logic               res_pulse_q, res_pulse_d;
  logic               res_dir_q, res_dir_d;
  logic [PosW-1:0]    res_pos_q, res_pos_d;
  logic               res_homed_q, res_homed_d;

  // Shared multiplier: |distance| times gain, saturated just above the rate range.
  logic [DistW-1:0]   mul_dist;
  logic [GainW-1:0]   mul_gain;
  logic [DistW-1:0]   mul_mag;
  logic [2*GainW-1:0] mul_full;
  logic [SatW-1:0]    mul_res;

  always_comb begin
    mul_dist = (state_q == srmc_pkg::StMulAccel) ? dist_start_q : dist_tgt_q;
    mul_gain = (state_q == srmc_pkg::StMulAccel) ? accel_gain_q : decel_gain_q;
    mul_mag  = mul_dist[DistW-1] ? (~mul_dist + DistW'(1)) : mul_dist;
    mul_full = mul_gain * mul_mag[GainW-1:0];
    if (mul_gain == '0) begin
      mul_res = '0;
    end else if ((mul_mag[DistW-1:GainW] != '0) || (mul_full[2*GainW-1:RateW] != '0)) begin
      mul_res = SatProduct;
    end else begin
      mul_res = {1'b0, mul_full[RateW-1:0]};
    end
  end

  // Divider step: one quotient bit per cycle.
  logic [SatW-1:0] div_trial;
  logic            div_ge;
  logic [SatW-1:0] div_diff;

  always_comb begin
    div_trial = {rem_q, quo_q[PeriodW-1]};
    div_ge    = div_trial >= divisor_q;
    div_diff  = div_trial - divisor_q;
  end

  logic               cmd_fire;
  logic               res_load;
  logic [PosW-1:0]    vel_mag;
  logic [RateW-1:0]   rate_sel;
  logic [SatW-1:0]    tr_tmp;
  logic               orr_ok;
  logic               step_fire;

  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign res_load = (state_q == srmc_pkg::StFinish) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d      = state_q;
    cur_pos_d    = cur_pos_q;
    tgt_pos_d    = tgt_pos_q;
    start_pos_d  = start_pos_q;
    dir_d        = dir_q;
    period_d     = period_q;
    step_ticks_d = step_ticks_q;
    ctl_ticks_d  = ctl_ticks_q;
    pos_mode_d   = pos_mode_q;
    home_d       = home_q;
    dir_pin_d    = dir_pin_q;
    op_d         = op_q;
    sw_d         = sw_q;
    dist_tgt_d   = dist_tgt_q;
    dist_start_d = dist_start_q;
    prod_tgt_d   = prod_tgt_q;
    prod_start_d = prod_start_q;
    divisor_d    = divisor_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    div_cnt_d    = div_cnt_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_pulse_d  = res_pulse_q;
    res_dir_d    = res_dir_q;
    res_pos_d    = res_pos_q;
    res_homed_d  = res_homed_q;
    vel_mag      = cmd_i.value[PosW-1] ? (~cmd_i.value + PosW'(1)) : cmd_i.value;
    rate_sel     = '0;
    tr_tmp       = '0;
    orr_ok       = 1'b0;
    step_fire    = 1'b0;

    unique case (state_q)
      srmc_pkg::StIdle: begin
        if (cmd_fire) begin
          op_d      = cmd_i.op;
          sw_d      = cmd_i.home_switch;
          rem_d     = '0;
          quo_d     = Dividend;
          div_cnt_d = '0;
          state_d   = srmc_pkg::StFinish;
          unique case (cmd_i.op)
            srmc_pkg::OpTick: begin
              if (pos_mode_q) begin
                if (ctl_ticks_q >= CtlDivide) begin
                  ctl_ticks_d = '0;
                  state_d     = srmc_pkg::StPrep;
                end else begin
                  ctl_ticks_d = ctl_ticks_q + TickW'(1);
                end
              end
            end
            srmc_pkg::OpTarget: begin
              tgt_pos_d  = cmd_i.value;
              home_d     = srmc_pkg::HomeOff;
              pos_mode_d = 1'b1;
            end
            srmc_pkg::OpVelocity, srmc_pkg::OpHome: begin
              pos_mode_d = 1'b0;
              home_d = (cmd_i.op == srmc_pkg::OpHome) ? srmc_pkg::HomeSearch
                                                      : srmc_pkg::HomeOff;
              if (cmd_i.value == '0) begin
                period_d    = srmc_pkg::PeriodSat;
                dir_d       = srmc_pkg::DirStop;
                tgt_pos_d   = cur_pos_q;
                start_pos_d = cur_pos_q;
              end else begin
                dir_d = cmd_i.value[PosW-1] ? srmc_pkg::DirMinus : srmc_pkg::DirPlus;
                // Speeds beyond the rate range give a zero period either way.
                divisor_d = (vel_mag[PosW-1:RateW] != '0) ? SatProduct
                                                          : {1'b0, vel_mag[RateW-1:0]};
                state_d   = srmc_pkg::StDiv;
              end
            end
            srmc_pkg::OpZero: begin
              cur_pos_d   = '0;
              tgt_pos_d   = '0;
              start_pos_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      srmc_pkg::StPrep: begin
        dist_tgt_d   = {tgt_pos_q[PosW-1], tgt_pos_q} - {cur_pos_q[PosW-1], cur_pos_q};
        dist_start_d = {cur_pos_q[PosW-1], cur_pos_q} - {start_pos_q[PosW-1], start_pos_q};
        state_d      = srmc_pkg::StMulDecel;
      end

      srmc_pkg::StMulDecel: begin
        prod_tgt_d = mul_res;
        state_d    = srmc_pkg::StMulAccel;
      end

      srmc_pkg::StMulAccel: begin
        prod_start_d = mul_res;
        state_d      = srmc_pkg::StSelect;
      end

      srmc_pkg::StSelect: begin
        if (prod_tgt_q == '0) begin
          dir_d = srmc_pkg::DirStop;
        end else begin
          dir_d = dist_tgt_q[DistW-1] ? srmc_pkg::DirMinus : srmc_pkg::DirPlus;
        end
        // The start term limits the rate only if zero or aimed the same way as the target.
        orr_ok = (prod_start_q == '0) || (dist_start_q[DistW-1] == dist_tgt_q[DistW-1]);
        tr_tmp = (orr_ok && (prod_start_q < prod_tgt_q)) ? prod_start_q : prod_tgt_q;
        if (tr_tmp > {1'b0, max_rate_q}) begin
          tr_tmp = {1'b0, max_rate_q};
        end
        rate_sel = tr_tmp[RateW-1:0];
        if (rate_sel < min_rate_q) begin
          rate_sel = min_rate_q;
        end
        if (rate_sel == '0) begin
          period_d = srmc_pkg::PeriodSat;
          state_d  = srmc_pkg::StFinish;
        end else begin
          divisor_d = {1'b0, rate_sel};
          state_d   = srmc_pkg::StDiv;
        end
      end

      srmc_pkg::StDiv: begin
        rem_d     = div_ge ? div_diff[PeriodW-1:0] : div_trial[PeriodW-1:0];
        quo_d     = {quo_q[PeriodW-2:0], div_ge};
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivLast) begin
          period_d = {quo_q[PeriodW-2:0], div_ge};
          state_d  = srmc_pkg::StFinish;
        end
      end

      srmc_pkg::StFinish: begin
        if (res_load) begin
          res_pulse_d = 1'b0;
          if (op_q == srmc_pkg::OpTick) begin
            if (step_ticks_q >= period_q) begin
              step_ticks_d = '0;
              if (dir_q != srmc_pkg::DirStop) begin
                step_fire = 1'b1;
                if (dir_q == srmc_pkg::DirPlus) begin
                  dir_pin_d = 1'b1;
                  cur_pos_d = cur_pos_q + PosW'(1);
                end else begin
                  dir_pin_d = 1'b0;
                  cur_pos_d = cur_pos_q - PosW'(1);
                end
              end
            end else begin
              step_ticks_d = step_ticks_q + TickW'(1);
            end
            if ((home_q == srmc_pkg::HomeSearch) && sw_q) begin
              cur_pos_d   = '0;
              tgt_pos_d   = '0;
              start_pos_d = '0;
              pos_mode_d  = 1'b1;
              home_d      = srmc_pkg::HomeFound;
            end
          end
          res_valid_d = 1'b1;
          res_pulse_d = step_fire;
          res_dir_d   = dir_pin_d;
          res_pos_d   = cur_pos_d;
          res_homed_d = (home_d == srmc_pkg::HomeFound);
          state_d     = srmc_pkg::StIdle;
        end
      end

      default: begin
        state_d = srmc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srmc_pkg::StIdle;
      cur_pos_q    <= '0;
      tgt_pos_q    <= '0;
      start_pos_q  <= '0;
      dir_q        <= srmc_pkg::DirStop;
      period_q     <= '0;
      step_ticks_q <= '0;
      ctl_ticks_q  <= '0;
      pos_mode_q   <= 1'b0;
      home_q       <= srmc_pkg::HomeOff;
      dir_pin_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_pos_q    <= cur_pos_d;
      tgt_pos_q    <= tgt_pos_d;
      start_pos_q  <= start_pos_d;
      dir_q        <= dir_d;
      period_q     <= period_d;
      step_ticks_q <= step_ticks_d;
      ctl_ticks_q  <= ctl_ticks_d;
      pos_mode_q   <= pos_mode_d;
      home_q       <= home_d;
      dir_pin_q    <= dir_pin_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    sw_q         <= sw_d;
    dist_tgt_q   <= dist_tgt_d;
    dist_start_q <= dist_start_d;
    prod_tgt_q   <= prod_tgt_d;
    prod_start_q <= prod_start_d;
    divisor_q    <= divisor_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    div_cnt_q    <= div_cnt_d;
    res_pulse_q  <= res_pulse_d;
    res_dir_q    <= res_dir_d;
    res_pos_q    <= res_pos_d;
    res_homed_q  <= res_homed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= srmc_pkg::AccelGainRst;
      decel_gain_q <= srmc_pkg::DecelGainRst;
      max_rate_q   <= srmc_pkg::MaxRateRst;
      min_rate_q   <= srmc_pkg::MinRateRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        srmc_pkg::RegAccelGain: accel_gain_q <= cfg_i.data;
        srmc_pkg::RegDecelGain: decel_gain_q <= cfg_i.data;
        srmc_pkg::RegMaxRate:   max_rate_q   <= cfg_i.data;
        srmc_pkg::RegMinRate:   min_rate_q   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_i.ready      = 1'b1;
  assign cmd_i.ready      = (state_q == srmc_pkg::StIdle);
  assign res_o.valid      = res_valid_q;
  assign res_o.step_pulse = res_pulse_q;
  assign res_o.step_dir   = res_dir_q;
  assign res_o.position   = res_pos_q;
  assign res_o.homed      = res_homed_q;

endmodule

[hw/rtl/srmc_checker.sv]
module srmc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cmd_valid_i,
  input logic                       cmd_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       res_step_pulse_i,
  input logic                       res_step_dir_i,
  input logic [srmc_pkg::PosW-1:0]  res_position_i,
  input logic                       res_homed_i,
  input logic                       cfg_ready_i
);

  // A stalled result keeps its place and its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_step_pulse_i) &&
      $stable(res_step_dir_i) && $stable(res_position_i) && $stable(res_homed_i))
    else $error("stalled result changed");

  // Taking a request makes the block busy until its result is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("request taken while another is in work");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!cmd_ready_i))
    else $error("result appeared without a request in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("register port not ready");

endmodule

bind stepper_ramp_motion_controller srmc_checker u_srmc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cmd_valid_i      (cmd_i.valid),
  .cmd_ready_i      (cmd_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_step_pulse_i (res_o.step_pulse),
  .res_step_dir_i   (res_o.step_dir),
  .res_position_i   (res_o.position),
  .res_homed_i      (res_o.homed),
  .cfg_ready_i      (cfg_i.ready)
);

[test/tb_top.sv]
module tb_top;
  import srmc_pkg::*;

  localparam int unsigned PhaseItems  = 175;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleCycles = 30;
  localparam longint      LimitTime   = 2_000_000;

  typedef struct packed {
    logic                    pulse;
    logic                    pin;
    logic signed [PosW-1:0]  pos;
    logic                    homed;
  } motion_report_t;

  // Tracks the controller state request by request and holds the reports
  // that the block still owes.
  class motion_tracker;
    logic [GainW-1:0]       acc_gain, dec_gain;
    logic [RateW-1:0]       rate_hi, rate_lo;
    logic signed [PosW-1:0] cur_pos, tgt_pos, start_pos;
    dir_e                   dir;
    home_e                  home;
    logic [PeriodW-1:0]     period;
    logic [TickCntW-1:0]    step_ticks, ctl_ticks;
    logic                   pos_mode, dir_pin;
    motion_report_t         owed_reports[$];
    int                     errors, checked, steps, homes, updates;

    function new();
      acc_gain = AccelGainRst;
      dec_gain = DecelGainRst;
      rate_hi = MaxRateRst;
      rate_lo = MinRateRst;
      cur_pos = '0;
      tgt_pos = '0;
      start_pos = '0;
      dir = DirStop;
      home = HomeOff;
      period = '0;
      step_ticks = '0;
      ctl_ticks = '0;
      pos_mode = 1'b0;
      dir_pin = 1'b0;
      errors = 0;
      checked = 0;
      steps = 0;
      homes = 0;
      updates = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function void flag(string msg);
      errors++;
      $error("%s", msg);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegAccelGain: acc_gain = data;
        RegDecelGain: dec_gain = data;
        RegMaxRate:   rate_hi = data;
        RegMinRate:   rate_lo = data;
        default: ;
      endcase
    endfunction

    function logic [PeriodW-1:0] period_for(longint rate);
      if (rate <= 0) return PeriodSat;
      return PeriodW'(longint'(TickRateDef) / rate);
    endfunction

    function void zero_all();
      cur_pos = '0;
      tgt_pos = '0;
      start_pos = '0;
    endfunction

    // Ramp update: the slower of the braking and the acceleration terms, then
    // clamped. Distances and products are exact, so 64-bit math is used.
    function void rerate();
      longint to_go, travelled, rate, ramp;
      to_go = longint'(dec_gain) * (longint'(tgt_pos) - longint'(cur_pos));
      travelled = longint'(acc_gain) * (longint'(cur_pos) - longint'(start_pos));
      if (to_go > 0) begin
        dir = DirPlus;
        rate = to_go;
        ramp = travelled;
      end else if (to_go < 0) begin
        dir = DirMinus;
        rate = -to_go;
        ramp = -travelled;
      end else begin
        dir = DirStop;
        rate = 0;
        ramp = 0;
      end
      // A ramp term that points away from the target does not limit the rate.
      if (ramp >= 0 && ramp < rate) rate = ramp;
      if (rate > longint'(rate_hi)) rate = longint'(rate_hi);
      if (rate < longint'(rate_lo)) rate = longint'(rate_lo);
      period = period_for(rate);
      updates++;
    endfunction

    function void set_speed(logic signed [PosW-1:0] value);
      longint v, mag;
      v = longint'(value);
      mag = (v < 0) ? -v : v;
      period = period_for(mag);
      if (v == 0) begin
        dir = DirStop;
        tgt_pos = cur_pos;
        start_pos = cur_pos;
      end else begin
        dir = (v > 0) ? DirPlus : DirMinus;
      end
      pos_mode = 1'b0;
    endfunction

    function void take_request(logic [OpW-1:0] op, logic signed [PosW-1:0] value,
                               logic sw);
      motion_report_t rep;
      logic pulse, fire;
      pulse = 1'b0;
      case (op)
        OpTick: begin
          if (pos_mode) begin
            fire = (ctl_ticks >= ControlDivideDef);
            ctl_ticks = ctl_ticks + 1'b1;
            if (fire) begin
              ctl_ticks = '0;
              rerate();
            end
          end
          fire = (step_ticks >= period);
          step_ticks = step_ticks + 1'b1;
          if (fire) begin
            step_ticks = '0;
            if (dir == DirPlus) begin
              dir_pin = 1'b1;
              cur_pos = cur_pos + 1;
              pulse = 1'b1;
            end else if (dir == DirMinus) begin
              dir_pin = 1'b0;
              cur_pos = cur_pos - 1;
              pulse = 1'b1;
            end
          end
          if (home == HomeSearch && sw) begin
            zero_all();
            pos_mode = 1'b1;
            home = HomeFound;
            homes++;
          end
        end
        OpTarget: begin
          tgt_pos = value;
          home = HomeOff;
          pos_mode = 1'b1;
        end
        OpVelocity: begin
          set_speed(value);
          home = HomeOff;
        end
        OpHome: begin
          set_speed(value);
          home = HomeSearch;
        end
        OpZero: zero_all();
        default: ;
      endcase
      rep.pulse = pulse;
      rep.pin = dir_pin;
      rep.pos = cur_pos;
      rep.homed = (home == HomeFound);
      owed_reports.push_back(rep);
    endfunction

    function void compare(string field, logic signed [PosW-1:0] want,
                          logic signed [PosW-1:0] got);
      if (got !== want)
        flag($sformatf("%s: expected %0d, got %0d", field, want, got));
    endfunction

    function void check_report(logic pulse, logic pin, logic signed [PosW-1:0] pos,
                               logic homed);
      motion_report_t want;
      if (owed_reports.size() == 0) begin
        flag($sformatf("result with no request outstanding, position %0d", pos));
        return;
      end
      want = owed_reports.pop_front();
      checked++;
      if (pulse === 1'b1) steps++;
      compare("step_pulse", want.pulse, pulse);
      compare("step_dir", want.pin, pin);
      compare("position", want.pos, pos);
      compare("homed", want.homed, homed);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  srmc_cmd_if cmd();
  srmc_res_if res();
  srmc_cfg_if cfg();

  stepper_ramp_motion_controller uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  motion_tracker tracker;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_req;
  int  sent;
  int  phase_end;
  int  cfg_writes;
  int  input_stalls;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(LimitTime);
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side: ready is chosen every falling edge; a long hold-off can be
  // requested by the stimulus process.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (res.valid && res.ready)
        tracker.check_report(res.step_pulse, res.step_dir, res.position, res.homed);
      if (cmd.valid && cmd.ready)
        tracker.take_request(cmd.op, cmd.value, cmd.home_switch);
      if (cmd.valid && !cmd.ready) input_stalls++;
    end
  end

  task automatic send_req(input logic [OpW-1:0] op, input logic [PosW-1:0] value,
                          input logic sw);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= op;
    cmd.value <= value;
    cmd.home_switch <= sw;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic tick_burst(input int n);
    for (int i = 0; i < n && sent < phase_end; i++)
      send_req(OpTick, $urandom, $urandom_range(99) < 5);
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic configure(input logic [GainW-1:0] acc, input logic [GainW-1:0] dec,
                           input logic [RateW-1:0] hi, input logic [RateW-1:0] lo,
                           input bit stray);
    cmd.valid <= 1'b0;
    drain();
    repeat (SettleCycles) @(negedge clk);
    write_reg(RegAccelGain, acc);
    write_reg(RegDecelGain, dec);
    write_reg(RegMaxRate, hi);
    write_reg(RegMinRate, lo);
    // An index past the last register must leave all settings alone.
    if (stray) write_reg(CfgIdxW'(RegMinRate + 1 + $urandom_range(11)), CfgDataW'($urandom));
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_sequence();
    int pick, off, spd;
    pick = $urandom_range(99);
    spd = int'($urandom_range(9000, 1));
    if ($urandom_range(1)) spd = -spd;
    if (pick < 40) begin
      if ($urandom_range(9) == 0) begin
        send_req(OpTarget, $urandom, 1'b0);
      end else begin
        off = int'($urandom_range(120)) - 60;
        send_req(OpTarget, tracker.cur_pos + off, 1'($urandom_range(1)));
      end
      tick_burst($urandom_range(150, 20));
    end else if (pick < 60) begin
      if ($urandom_range(19) == 0) spd = 0;
      else if ($urandom_range(6) == 0) spd = $urandom;
      send_req(OpVelocity, spd, 1'($urandom_range(1)));
      tick_burst($urandom_range(60, 5));
    end else if (pick < 75) begin
      send_req(OpHome, spd, 1'b0);
      tick_burst($urandom_range(40, 3));
      if ($urandom_range(99) < 80) send_req(OpTick, $urandom, 1'b1);
      tick_burst($urandom_range(10));
    end else if (pick < 85) begin
      send_req(OpZero, $urandom, 1'($urandom_range(1)));
      tick_burst($urandom_range(10, 1));
    end else begin
      repeat ($urandom_range(8, 1))
        send_req(OpW'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    bit pressed, paused;
    tracker = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    sent = 0;
    phase_end = 32'h7FFF_FFFF;
    cfg_writes = 0;
    input_stalls = 0;
    pressed = 1'b0;
    paused = 1'b0;
    rst_n = 1'b0;
    cmd.valid = 1'b0;
    cmd.op = OpTick;
    cmd.value = '0;
    cmd.home_switch = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = RegAccelGain;
    cfg.data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed checks on the reset settings.
    send_req(OpTick, '0, 1'b0);
    send_req(OpTick, 32'hFFFF_FFFF, 1'b1);
    send_req(OpZero + 3'd1, 32'h7FFF_FFFF, 1'b1);
    send_req(OpZero + 3'd2, 32'h8000_0000, 1'b0);
    send_req(OpZero + 3'd3, 32'hFFFF_FFFF, 1'b1);
    send_req(OpVelocity, 32'sd8000, 1'b0);
    tick_burst(2);
    send_req(OpVelocity, 32'h8000_0000, 1'b0);
    tick_burst(2);
    send_req(OpVelocity, 32'h7FFF_FFFF, 1'b0);
    send_req(OpTick, '0, 1'b0);
    send_req(OpVelocity, '0, 1'b0);
    send_req(OpTick, '0, 1'b0);
    send_req(OpZero, 32'h5555_AAAA, 1'b0);
    send_req(OpHome, -32'sd1, 1'b0);
    send_req(OpTick, '0, 1'b0);
    send_req(OpTick, '0, 1'b1);
    send_req(OpTick, '0, 1'b0);
    send_req(OpTarget, 32'h7FFF_FFFF, 1'b0);
    send_req(OpTarget, 32'h8000_0000, 1'b0);
    send_req(OpTick, '0, 1'b0);
    send_req(OpHome, '0, 1'b0);
    send_req(OpTick, '0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(16'hFFFF, 16'hFFFF, 16'd8000, 16'd2000, 1'b0);
        1: configure('0, 16'd1, '0, '0, 1'b0);
        2: configure(16'd300, 16'd500, 16'hFFFF, 16'hFFFF, 1'b1);
        3: configure(GainW'($urandom), GainW'($urandom), 16'd1000, 16'd4000, 1'b0);
        4: configure(GainW'($urandom_range(200, 1)), GainW'($urandom_range(200, 1)),
                     RateW'($urandom_range(9000, 2000)), RateW'($urandom_range(100)), 1'b0);
        default: configure(GainW'($urandom), GainW'($urandom), RateW'($urandom),
                           RateW'($urandom), 1'b0);
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      phase_end = sent + PhaseItems;
      while (sent < phase_end) begin
        // Hold the result side off while ticks keep coming, so the output
        // register fills and the command side has to stall.
        if (ph == 0 && !pressed && sent > phase_end - PhaseItems) begin
          pressed = 1'b1;
          hold_req = 1'b1;
          tick_burst(16);
        end
        if (ph == 4 && !paused && sent > phase_end - PhaseItems) begin
          paused = 1'b1;
          cmd.valid <= 1'b0;
          drain();
        end
        run_sequence();
      end
    end
    cmd.valid <= 1'b0;

    drain();
    repeat (40) @(negedge clk);
    if (tracker.pending() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.pending()));
    $display("Run covered %0d requests, %0d checked results and %0d register writes.",
             sent, tracker.checked, cfg_writes);
    $display("Seen %0d steps, %0d ramp updates, %0d home hits, %0d stalled input cycles.",
             tracker.steps, tracker.updates, tracker.homes, input_stalls);
    if (tracker.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
